// ===== sv/edps_pkg.sv =====
// ============================================================================
// edps_pkg: shared types and constants of the periodic task scheduler
// Holds the opcode and status codes, the word layouts of both channels, the
// layout of one table slot and the sequencer states.
// ============================================================================
package edps_pkg;

    localparam int ENTRIES_DEF = 16;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_EXECUTE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_opcode;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  task_id;
        logic [15:0] period_ms;
        logic [31:0] now_ms;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        run_valid;
        logic [7:0]  run_task_id;
        logic [31:0] next_due_ms;
    } t_res_word;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] period_ms;
        logic [31:0] last_run;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_RD,
        S_RDW,
        S_DONE
    } t_state;

endpackage

// ===== sv/edps_stream_if.sv =====
// ============================================================================
// edps_stream_if: valid/ready channel carrying one word
// The source drives valid and the payload, the sink drives ready.
// ============================================================================
interface edps_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/edps_ram.sv =====
// ============================================================================
// edps_ram: generic single-write, single-read RAM
// One write port and one read port with the read data registered.
// ============================================================================
module edps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/earliest_due_periodic_scheduler_core.sv =====
// ============================================================================
// earliest_due_periodic_scheduler_core: earliest-due periodic task table
// Holds ENTRIES periodic tasks and picks the one whose due time comes first.
// ============================================================================
// Usage. Command words arrive on i_cmd (opcode, task id, period, current
// time) and each one gives exactly one result word on o_res (status, run
// flag, task id that ran, next due time). i_cmd is ready only while the
// sequencer is idle; one command is worked on at a time.
// Sequence per command, from the command being taken to the output register
// being loaded: clear goes straight to the output stage. Add walks the
// slot-used flags for the lowest free slot. Remove reads every slot through
// the single RAM read port. Execute reads the chosen slot, writes the new
// stamp, then rescans the table with the one due-time adder and comparator,
// after a first scan of the table when no task was chosen beforehand. The
// RAM read port and the shared comparator set the length of each sequence.
// The next command can be taken in the cycle after the output register is
// loaded.
// Reset clears every slot-used flag and forgets the chosen task at once;
// the slot contents themselves are not cleared.
// When the receiver stalls, the finished word waits in the output register
// and the next command is still taken; the sequencer only holds in its last
// state if a second result is ready before the first has been taken.
// ============================================================================
module earliest_due_periodic_scheduler_core
    import edps_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    edps_stream_if.sink          i_cmd,
    edps_stream_if.source        o_res
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);

    // Sequencer and scan control.
    t_state           r_state, n_state;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [IW-1:0]    r_pidx, n_pidx;
    t_opcode          r_op, n_op;
    logic             r_pass, n_pass;

    // Table flags and the chosen task.
    logic [ENTRIES-1:0] r_used, n_used;
    logic [IW-1:0]    r_chosen_slot, n_chosen_slot;
    logic             r_chosen_valid, n_chosen_valid;
    logic [31:0]      r_chosen_due, n_chosen_due;

    // Command operands and result being built.
    logic [7:0]       r_id, n_id;
    logic [15:0]      r_period, n_period;
    logic [31:0]      r_now, n_now;
    logic [1:0]       r_status, n_status;
    logic             r_run_valid, n_run_valid;
    logic [7:0]       r_run_id, n_run_id;
    logic [31:0]      r_next_due, n_next_due;

    // Output register.
    logic             r_out_valid, n_out_valid;
    t_res_word        r_out_word, n_out_word;

    // Slot RAM.
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    t_slot            ram_wdata;
    logic [IW-1:0]    ram_raddr;
    t_slot            ram_rdata;
    logic [31:0]      slot_due;

    edps_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The one due-time adder shared by every scan step.
    assign slot_due = ram_rdata.last_run + {16'd0, ram_rdata.period_ms};

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out_word;

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_pend         = 1'b0;
        n_pidx         = r_pidx;
        n_op           = r_op;
        n_pass         = r_pass;
        n_used         = r_used;
        n_chosen_slot  = r_chosen_slot;
        n_chosen_valid = r_chosen_valid;
        n_chosen_due   = r_chosen_due;
        n_id           = r_id;
        n_period       = r_period;
        n_now          = r_now;
        n_status       = r_status;
        n_run_valid    = r_run_valid;
        n_run_id       = r_run_id;
        n_next_due     = r_next_due;
        n_out_valid    = r_out_valid & ~o_res.ready;
        n_out_word     = r_out_word;
        ram_we         = 1'b0;
        ram_waddr      = r_chosen_slot;
        ram_wdata      = '0;
        ram_raddr      = r_idx[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op        = t_opcode'(i_cmd.payload.opcode);
                    n_id        = i_cmd.payload.task_id;
                    n_period    = i_cmd.payload.period_ms;
                    n_now       = i_cmd.payload.now_ms;
                    n_status    = ST_OK;
                    n_run_valid = 1'b0;
                    n_run_id    = 8'd0;
                    n_next_due  = 32'd0;
                    n_idx       = '0;
                    n_pass      = 1'b0;
                    unique case (t_opcode'(i_cmd.payload.opcode))
                        OP_ADD: begin
                            n_state = S_ADD;
                        end
                        OP_REMOVE: begin
                            n_chosen_valid = 1'b0;
                            n_state        = S_SCAN;
                        end
                        OP_EXECUTE: begin
                            if (r_chosen_valid && r_used[r_chosen_slot]) begin
                                n_state = S_RD;
                            end else begin
                                n_chosen_valid = 1'b0;
                                n_state        = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_used         = '0;
                            n_chosen_valid = 1'b0;
                            n_state        = S_DONE;
                        end
                    endcase
                end
            end

            S_ADD: begin
                // Walk the used flags upwards to the lowest free slot.
                if (r_idx == LAST_CNT) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else if (!r_used[r_idx[IW-1:0]]) begin
                    ram_we                 = 1'b1;
                    ram_waddr              = r_idx[IW-1:0];
                    ram_wdata.task_id      = r_id;
                    ram_wdata.period_ms    = r_period;
                    ram_wdata.last_run     = r_now;
                    n_used[r_idx[IW-1:0]]  = 1'b1;
                    n_state                = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_SCAN: begin
                // Issue one read a cycle; the data of the previous read is
                // handled in the same cycle.
                if (r_idx != LAST_CNT) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[IW-1:0];
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pend && r_used[r_pidx]) begin
                    if (r_op == OP_REMOVE) begin
                        if (ram_rdata.task_id == r_id) begin
                            n_used[r_pidx] = 1'b0;
                        end
                    end else if (!r_chosen_valid || (slot_due < r_chosen_due)) begin
                        n_chosen_slot  = r_pidx;
                        n_chosen_valid = 1'b1;
                        n_chosen_due   = slot_due;
                    end
                end
                if ((r_idx == LAST_CNT) && !r_pend) begin
                    if (r_op == OP_REMOVE) begin
                        n_state = S_DONE;
                    end else if (!r_pass) begin
                        if (r_chosen_valid) begin
                            n_state = S_RD;
                        end else begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_run_valid = 1'b1;
                        n_next_due  = r_chosen_due;
                        n_state     = S_DONE;
                    end
                end
            end

            S_RD: begin
                ram_raddr = r_chosen_slot;
                n_state   = S_RDW;
            end

            S_RDW: begin
                // Report the chosen task, stamp it and rescan from slot zero.
                n_run_id            = ram_rdata.task_id;
                ram_we              = 1'b1;
                ram_waddr           = r_chosen_slot;
                ram_wdata.task_id   = ram_rdata.task_id;
                ram_wdata.period_ms = ram_rdata.period_ms;
                ram_wdata.last_run  = r_now;
                n_chosen_due        = r_now + {16'd0, ram_rdata.period_ms};
                n_pass              = 1'b1;
                n_idx               = '0;
                n_state             = S_SCAN;
            end

            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid            = 1'b1;
                    n_out_word.status      = r_status;
                    n_out_word.run_valid   = r_run_valid;
                    n_out_word.run_task_id = r_run_id;
                    n_out_word.next_due_ms = r_next_due;
                    n_state                = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_idx          <= '0;
            r_pend         <= 1'b0;
            r_pass         <= 1'b0;
            r_used         <= '0;
            r_chosen_slot  <= '0;
            r_chosen_valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_idx          <= n_idx;
            r_pend         <= n_pend;
            r_pass         <= n_pass;
            r_used         <= n_used;
            r_chosen_slot  <= n_chosen_slot;
            r_chosen_valid <= n_chosen_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx       <= n_pidx;
        r_op         <= n_op;
        r_chosen_due <= n_chosen_due;
        r_id         <= n_id;
        r_period     <= n_period;
        r_now        <= n_now;
        r_status     <= n_status;
        r_run_valid  <= n_run_valid;
        r_run_id     <= n_run_id;
        r_next_due   <= n_next_due;
        r_out_word   <= n_out_word;
    end
endmodule

// ===== test/tb_earliest_due_periodic_scheduler_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_earliest_due_periodic_scheduler_core: self-checking bench of the scheduler
// Drives command words into the task table and checks every result word
// against a behavioural copy of the table kept in this bench. Directed cases
// cover the field extremes, all four opcodes, wrap of the due time, ties,
// duplicate ids and a full table. Random traffic with idle gaps on both
// sides follows, including a long result stall that backs up the command side.
// ============================================================================
module tb_earliest_due_periodic_scheduler_core;
    import edps_pkg::*;

    localparam int N_SLOTS     = ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 50;
    localparam int MAX_REPORTS = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    edps_stream_if #(.t_payload(t_cmd_word)) cmd_if ();
    edps_stream_if #(.t_payload(t_res_word)) res_if ();

    earliest_due_periodic_scheduler_core #(
        .ENTRIES (N_SLOTS)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    // 10 ns clock, low half first.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioural copy of the task table. It is advanced once per accepted
    // command word, in acceptance order, so it always mirrors the block.
    // ------------------------------------------------------------------------
    bit          tbl_used   [N_SLOTS];
    logic [7:0]  tbl_id     [N_SLOTS];
    logic [15:0] tbl_period [N_SLOTS];
    logic [31:0] tbl_stamp  [N_SLOTS];
    int          sel_slot  = 0;
    bit          sel_valid = 1'b0;

    // Result words owed by the block, oldest first.
    t_res_word   outcome_q [$];

    int          fail_count = 0;
    int          cycle_count = 0;

    // Shared knobs between the stimulus and the result sink.
    bit          no_idle  = 1'b0;
    int          hold_len = 0;
    logic [31:0] clock_ms = '0;

    // Due time wraps modulo 2^32, exactly as the block's adder does.
    function automatic logic [31:0] due_at(int s);
        due_at = tbl_stamp[s] + {16'd0, tbl_period[s]};
    endfunction

    // Scan from the lowest slot; a later slot only wins on a strictly earlier
    // due time, so ties keep the earlier choice and then the lowest slot.
    function automatic void pick_earliest_due();
        int s;
        if (sel_valid && !tbl_used[sel_slot]) sel_valid = 1'b0;
        for (s = 0; s < N_SLOTS; s++) begin
            if (tbl_used[s]) begin
                if (!sel_valid) begin
                    sel_slot  = s;
                    sel_valid = 1'b1;
                end else if (due_at(s) < due_at(sel_slot)) begin
                    sel_slot = s;
                end
            end
        end
    endfunction

    // Applies one command word to the table copy and returns the result word
    // that the block owes for it.
    function automatic t_res_word apply_command(t_cmd_word c);
        t_res_word r;
        int        s;
        int        free_slot;
        r = '0;
        case (c.opcode)
            OP_ADD: begin
                free_slot = -1;
                for (s = 0; s < N_SLOTS; s++)
                    if (!tbl_used[s] && free_slot < 0) free_slot = s;
                if (free_slot >= 0) begin
                    tbl_used[free_slot]   = 1'b1;
                    tbl_id[free_slot]     = c.task_id;
                    tbl_period[free_slot] = c.period_ms;
                    tbl_stamp[free_slot]  = c.now_ms;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                for (s = 0; s < N_SLOTS; s++)
                    if (tbl_used[s] && tbl_id[s] == c.task_id) tbl_used[s] = 1'b0;
                sel_valid = 1'b0;
            end
            OP_EXECUTE: begin
                if (!sel_valid || !tbl_used[sel_slot]) begin
                    sel_valid = 1'b0;
                    pick_earliest_due();
                end
                if (sel_valid) begin
                    r.run_valid       = 1'b1;
                    r.run_task_id     = tbl_id[sel_slot];
                    tbl_stamp[sel_slot] = c.now_ms;
                    pick_earliest_due();
                    r.next_due_ms     = due_at(sel_slot);
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            OP_CLEAR: begin
                for (s = 0; s < N_SLOTS; s++) tbl_used[s] = 1'b0;
                sel_valid = 1'b0;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge; a result word is
    // checked against the oldest owed word, and an accepted command word adds
    // its owed result at the back.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_res_word got;
        t_res_word want;
        if (rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got = res_if.payload;
                if (outcome_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result word with nothing owed: %p", $realtime, got);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status !== want.status || got.run_valid !== want.run_valid ||
                        got.run_task_id !== want.run_task_id ||
                        got.next_due_ms !== want.next_due_ms) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: mismatch status %0d/%0d run %0d/%0d id %0d/%0d due %h/%h",
                                     $realtime, want.status, got.status,
                                     want.run_valid, got.run_valid,
                                     want.run_task_id, got.run_task_id,
                                     want.next_due_ms, got.next_due_ms);
                    end
                end
            end
            if (cmd_if.valid && cmd_if.ready)
                outcome_q.push_back(apply_command(cmd_if.payload));
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink. Before each word it stalls for a random number of cycles,
    // none during no-idle stretches, or for the long hold when one is asked.
    // Ready is never dropped and raised within the same edge.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        res_if.ready = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_len != 0) begin
                stall    = hold_len;
                hold_len = 0;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 10);
            end
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!(res_if.valid && res_if.ready));
            @(negedge clk);
        end
    end

    function automatic t_cmd_word make_cmd(t_opcode op, logic [7:0] id,
                                           logic [15:0] period, logic [31:0] now);
        t_cmd_word w;
        w.opcode    = op;
        w.task_id   = id;
        w.period_ms = period;
        w.now_ms    = now;
        return w;
    endfunction

    // Sends one command word. Entered and left at a falling edge; valid stays
    // high into the next word when no gap is drawn.
    task automatic send_cmd(input t_cmd_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.payload <= w;
        cmd_if.valid   <= 1'b1;
        do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
        @(negedge clk);
    endtask

    // Empty table on execute, field extremes, due-time wrap, absent remove
    // and clear.
    task automatic test_directed_basics();
        send_cmd(make_cmd(OP_EXECUTE, 8'h3C, 16'h1234, 32'h1234_5678));
        send_cmd(make_cmd(OP_ADD, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_ADD, 8'h00, 16'h0000, 32'h0000_0000));
        send_cmd(make_cmd(OP_EXECUTE, 8'h00, 16'h0000, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_REMOVE, 8'h5A, 16'h0000, 32'h0000_0000));
        send_cmd(make_cmd(OP_EXECUTE, 8'h00, 16'h0000, 32'h0001_0000));
        send_cmd(make_cmd(OP_CLEAR, 8'hAA, 16'h5555, 32'hAAAA_5555));
        send_cmd(make_cmd(OP_EXECUTE, 8'h55, 16'hAAAA, 32'h5555_AAAA));
    endtask

    // Fills the table with tied due times and duplicate ids, overflows it,
    // then removes a duplicated id and refills the lowest free slot.
    task automatic test_table_full();
        int k;
        for (k = 0; k < N_SLOTS; k++)
            send_cmd(make_cmd(OP_ADD, 8'(k % 4), 16'd100, 32'd1000));
        send_cmd(make_cmd(OP_ADD, 8'hA5, 16'd7, 32'd1050));
        send_cmd(make_cmd(OP_EXECUTE, 8'h00, 16'd0, 32'd1100));
        send_cmd(make_cmd(OP_REMOVE, 8'h01, 16'd0, 32'd0));
        send_cmd(make_cmd(OP_ADD, 8'h09, 16'd1, 32'd1200));
        send_cmd(make_cmd(OP_EXECUTE, 8'h00, 16'd0, 32'd1300));
    endtask

    // Mostly well-formed traffic on a running millisecond clock, with a share
    // of fully random words as noise. add_pct steers how often the table fills.
    task automatic test_random_traffic(input int count, input bit idle_on,
                                       input int add_pct, input logic [31:0] start_ms);
        int          n;
        int          pick;
        t_opcode     op;
        logic [7:0]  id;
        logic [15:0] period;
        t_cmd_word   w;
        no_idle  = !idle_on;
        clock_ms = start_ms;
        for (n = 0; n < count; n++) begin
            clock_ms += 32'($urandom_range(0, 40));
            pick = $urandom_range(0, 99);
            if (pick < add_pct)  op = OP_ADD;
            else if (pick < 85)  op = OP_EXECUTE;
            else if (pick < 97)  op = OP_REMOVE;
            else                 op = OP_CLEAR;
            // A small id pool makes duplicates and hits on remove common.
            id = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            case ($urandom_range(0, 9))
                0:       period = 16'h0000;
                1:       period = 16'hFFFF;
                2:       period = 16'($urandom);
                default: period = 16'($urandom_range(1, 200));
            endcase
            if ($urandom_range(0, 19) == 0)
                w = make_cmd(t_opcode'($urandom_range(0, 3)), 8'($urandom),
                             16'($urandom), $urandom);
            else
                w = make_cmd(op, id, period, clock_ms);
            send_cmd(w);
        end
        no_idle = 1'b0;
    endtask

    // The sink holds off for a long stretch while words are offered back to
    // back, so the output register and the sequencer fill and the command
    // side stalls.
    task automatic test_back_pressure();
        int k;
        // The last word has been taken; withdraw it while the block drains.
        cmd_if.valid <= 1'b0;
        while (outcome_q.size() != 0) @(negedge clk);
        no_idle  = 1'b1;
        hold_len = 300;
        send_cmd(make_cmd(OP_CLEAR, 8'h00, 16'h0000, 32'h0000_0000));
        for (k = 0; k < N_SLOTS; k++)
            send_cmd(make_cmd(OP_ADD, 8'(k * 7), 16'(k + 3), 32'(k)));
        send_cmd(make_cmd(OP_ADD, 8'hEE, 16'h0001, 32'h0000_0100));
        send_cmd(make_cmd(OP_EXECUTE, 8'h00, 16'h0000, 32'h0000_0200));
        send_cmd(make_cmd(OP_EXECUTE, 8'h00, 16'h0000, 32'h0000_0300));
        no_idle = 1'b0;
    endtask

    initial begin
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_basics();
        test_table_full();
        test_random_traffic(700, 1'b1, 30, $urandom);
        test_random_traffic(300, 1'b0, 45, 32'hFFFF_FF00);
        test_back_pressure();
        test_random_traffic(850, 1'b1, 50, 32'($urandom_range(0, 1000)));

        cmd_if.valid <= 1'b0;
        while (outcome_q.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
